// File: design/button_press_long_press_detector_assert.svh
// ----------------------------------------------------------------------------
// Button press detector assertion macros
// Shared property forms for the detector's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_LONG_PRESS_DETECTOR_ASSERT_SVH
`define BUTTON_PRESS_LONG_PRESS_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPLPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPLPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bplpd_pkg.sv
// ----------------------------------------------------------------------------
// Button press detector package
// Event codes, field widths and the lane/merge post records.
// ----------------------------------------------------------------------------
package bplpd_pkg;

	localparam int LEVEL_W  = 3;   // width of the button level field
	localparam int BTN_W    = 2;   // width of the reported button index
	localparam int EV_W     = 2;   // width of the event code
	localparam int THRESH_W = 32;  // width of the long-press threshold
	localparam int TICK_IN_W = 32; // width of the tick field

	localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd1000;

	localparam logic [EV_W-1:0] EV_PRESS        = 2'd0;
	localparam logic [EV_W-1:0] EV_SHORT        = 2'd1;
	localparam logic [EV_W-1:0] EV_LONG         = 2'd2;
	localparam logic [EV_W-1:0] EV_RELEASE_LONG = 2'd3;

	// One lane's outcome for the current poll.
	typedef struct packed {
		logic            post;
		logic [EV_W-1:0] ev;
	} lane_post_t;

	// Winning event after the merge.
	typedef struct packed {
		logic             hit;
		logic [BTN_W-1:0] button;
		logic [EV_W-1:0]  ev;
	} merge_post_t;

endpackage

// File: design/button_press_long_press_detector.sv
// ----------------------------------------------------------------------------
// Button press / long press detector
// Per-button press, click and long-press detection with a one-slot mailbox.
// ----------------------------------------------------------------------------
// Every request on the slave side returns exactly one result on the master
// side. A poll request (tuser = 0) carries the button levels and the current
// tick; each button lane compares its elapsed hold time with the long-press
// threshold in parallel, and the merge stage posts the highest-index event to
// the mailbox. The result is the mailbox after the poll. A read request
// (tuser = 1) returns the mailbox and empties it. A request is taken in the
// same cycle it is offered whenever the output register is empty or being drained,
// so the block sustains one request per clock; the only latency is the single
// output register. The threshold is to be written by the user through cfg_we
// and cfg_wdata only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module button_press_long_press_detector import bplpd_pkg::*; #(
	parameter int BUTTON_COUNT = 3,
	parameter int TICK_WIDTH   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [39:0]         s_tdata,  // [2:0] button_levels, [34:3] tick_now, rest zero
	input  logic                s_tuser,  // [0] mode
	// result channel
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,  // [0] msg_valid, [2:1] msg_button,
	                                      // [4:3] msg_event, rest zero
	// threshold register
	input  logic                cfg_we,
	input  logic [THRESH_W-1:0] cfg_wdata
);

	logic                  accept;
	logic                  is_read;
	logic                  poll_en;
	logic [LEVEL_W-1:0]    levels;
	logic [TICK_WIDTH-1:0] now;

	logic [THRESH_W-1:0]   thresh_q;

	// mailbox
	logic                  mbox_valid_q;
	logic [BTN_W-1:0]      mbox_button_q;
	logic [EV_W-1:0]       mbox_event_q;

	// output register
	logic                  out_valid_q;
	logic [7:0]            out_data_q;

	lane_post_t            lane_res [BUTTON_COUNT];
	merge_post_t           win;

	// Unpack the request; the tick is folded into the counter width.
	assign levels  = s_tdata[LEVEL_W-1:0];
	assign now     = TICK_WIDTH'(s_tdata[LEVEL_W +: TICK_IN_W]);
	assign is_read = s_tuser;

	// Take a new request whenever the result slot is free or draining.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign poll_en  = accept && !is_read;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	// One lane per button; buttons past the level field never read as pressed.
	for (genvar gi = 0; gi < BUTTON_COUNT; gi++) begin : g_lane
		logic pressed;
		if (gi < LEVEL_W) begin : g_lvl
			assign pressed = levels[gi];
		end else begin : g_none
			assign pressed = 1'b0;
		end

		bplpd_lane #(
			.TICK_WIDTH(TICK_WIDTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.poll_en(poll_en),
			.pressed(pressed),
			.now    (now),
			.thresh (thresh_q),
			.result (lane_res[gi])
		);
	end

	// Highest button index wins within one poll.
	bplpd_merge #(
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_merge (
		.lanes(lane_res),
		.win  (win)
	);

	// Mailbox: clear on read, overwrite on any posted event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbox_valid_q  <= 1'b0;
			mbox_button_q <= '0;
			mbox_event_q  <= EV_PRESS;
		end else if (accept) begin
			if (is_read) begin
				mbox_valid_q  <= 1'b0;
				mbox_button_q <= '0;
				mbox_event_q  <= EV_PRESS;
			end else if (win.hit) begin
				mbox_valid_q  <= 1'b1;
				mbox_button_q <= win.button;
				mbox_event_q  <= win.ev;
			end
		end
	end

	// Result register: a read reports the mailbox before clearing, a poll
	// reports it after the update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_read || !win.hit) begin
				out_data_q <= {3'b000, mbox_event_q, mbox_button_q, mbox_valid_q};
			end else begin
				out_data_q <= {3'b000, win.ev, win.button, 1'b1};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`include "button_press_long_press_detector_assert.svh"

	// A read always leaves the mailbox empty.
	`BPLPD_ASSERT_NEXT(a_read_clears, accept && is_read, !mbox_valid_q, "mailbox not cleared by read")
	// Any posting lane in a poll fills the mailbox.
	`BPLPD_ASSERT_NEXT(a_post_fills, poll_en && win.hit, mbox_valid_q, "posted event lost")
	// A stalled result blocks new requests.
	`BPLPD_ASSERT_NOW(a_no_overrun, out_valid_q && !m_tready, !s_tready, "result overrun")
	// An empty mailbox reports all-zero fields.
	`BPLPD_ASSERT_NOW(a_empty_zero, !mbox_valid_q, mbox_button_q == '0 && mbox_event_q == EV_PRESS, "stale mailbox fields")

endmodule

// File: design/bplpd_lane.sv
// ----------------------------------------------------------------------------
// Button press detector lane
// Per-button state: last level, long-press flag and start tick.
// ----------------------------------------------------------------------------
module bplpd_lane import bplpd_pkg::*; #(
	parameter int TICK_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  poll_en,
	input  logic                  pressed,
	input  logic [TICK_WIDTH-1:0] now,
	input  logic [THRESH_W-1:0]   thresh,
	output lane_post_t            result
);

	localparam int CMP_W = (TICK_WIDTH > THRESH_W) ? TICK_WIDTH : THRESH_W;

	logic                  released_q;
	logic                  long_q;
	logic [TICK_WIDTH-1:0] start_q;
	logic [TICK_WIDTH-1:0] elapsed;
	logic                  over;

	assign elapsed = now - start_q;
	assign over    = CMP_W'(elapsed) > CMP_W'(thresh);

	always_comb begin
		result.post = 1'b0;
		result.ev   = EV_PRESS;
		if (!pressed) begin
			if (!released_q) begin
				result.post = 1'b1;
				result.ev   = long_q ? EV_RELEASE_LONG : EV_SHORT;
			end
		end else begin
			if (!long_q && over) begin
				result.post = 1'b1;
				result.ev   = EV_LONG;
			end else if (released_q) begin
				result.post = 1'b1;
				result.ev   = EV_PRESS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			released_q <= 1'b1;
			long_q     <= 1'b0;
			start_q    <= '0;
		end else if (poll_en) begin
			if (!pressed) begin
				released_q <= 1'b1;
				long_q     <= 1'b0;
				start_q    <= now;
			end else begin
				released_q <= 1'b0;
				if (over) begin
					long_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: design/bplpd_merge.sv
// ----------------------------------------------------------------------------
// Button press detector merge
// Pick the highest-index lane that posted an event in this poll.
// ----------------------------------------------------------------------------
module bplpd_merge import bplpd_pkg::*; #(
	parameter int BUTTON_COUNT = 3
) (
	input  lane_post_t  lanes [BUTTON_COUNT],
	output merge_post_t win
);

	always_comb begin
		win = '0;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			if (lanes[i].post) begin
				win.hit    = 1'b1;
				win.button = BTN_W'(i);
				win.ev     = lanes[i].ev;
			end
		end
	end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Button press detector testbench
// Sends poll and read requests to the detector and checks every mailbox
// result against a cycle-free model of the button lanes. A short table of
// hand-picked requests comes first. Random phases follow, each with its own
// long-press threshold, and both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bplpd_pkg::*;

	localparam logic MODE_POLL = 1'b0;
	localparam logic MODE_READ = 1'b1;
	localparam int   QUIET_LIMIT = 2000;   // cycles with no handshake before giving up
	localparam int   PHASE_ITEMS = 197;

	// Mailbox as seen on m_tdata.
	typedef struct packed {
		logic             valid;
		logic [BTN_W-1:0] button;
		logic [EV_W-1:0]  ev;
	} mbox_msg_t;

	localparam mbox_msg_t NO_MSG = '0;

	// One row of the directed table; want is used only where has_want is set.
	typedef struct packed {
		logic                 mode;
		logic [LEVEL_W-1:0]   levels;
		logic [TICK_IN_W-1:0] tick;
		logic                 has_want;
		mbox_msg_t            want;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [39:0]         s_tdata;   // [2:0] button_levels, [34:3] tick_now, rest zero
	logic                s_tuser;   // [0] mode
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;   // [0] msg_valid, [2:1] msg_button, [4:3] msg_event
	logic                cfg_we;
	logic [THRESH_W-1:0] cfg_wdata;

	// Model state: one lane per button plus the one-slot mailbox.
	logic [THRESH_W-1:0]  long_limit = THRESH_RESET;
	logic [2:0]           btn_up     = 3'b111;
	logic [2:0]           long_hit   = 3'b000;
	logic [TICK_IN_W-1:0] hold_start [3] = '{default: '0};
	mbox_msg_t            mbox       = NO_MSG;

	mbox_msg_t expected_msgs [$];
	int        mismatches = 0;
	int        requests_sent = 0;
	int        quiet_cycles = 0;

	// Hand-picked requests, threshold at its reset value of 1000.
	stim_row_t directed_rows [23] = '{
		// empty mailbox straight after reset
		'{MODE_READ, 3'b000, 32'h0000_0000, 1'b1, NO_MSG},
		'{MODE_POLL, 3'b000, 32'h0000_0000, 1'b1, NO_MSG},
		'{MODE_POLL, 3'b001, 32'd10,        1'b1, '{1'b1, 2'd0, EV_PRESS}},
		// held exactly the threshold: not yet long
		'{MODE_POLL, 3'b001, 32'd1000,      1'b1, '{1'b1, 2'd0, EV_PRESS}},
		'{MODE_POLL, 3'b001, 32'd1001,      1'b1, '{1'b1, 2'd0, EV_LONG}},
		'{MODE_READ, 3'b111, 32'hFFFF_FFFF, 1'b1, '{1'b1, 2'd0, EV_LONG}},
		'{MODE_READ, 3'b000, 32'h0000_0000, 1'b1, NO_MSG},
		'{MODE_POLL, 3'b000, 32'd1100,      1'b1, '{1'b1, 2'd0, EV_RELEASE_LONG}},
		// all buttons at once: the highest index wins
		'{MODE_POLL, 3'b111, 32'd1200,      1'b1, '{1'b1, 2'd2, EV_PRESS}},
		'{MODE_POLL, 3'b000, 32'd1300,      1'b1, '{1'b1, 2'd2, EV_SHORT}},
		'{MODE_READ, 3'b000, 32'h0000_0000, 1'b1, '{1'b1, 2'd2, EV_SHORT}},
		// press and long press in the same poll: long overwrites
		'{MODE_POLL, 3'b100, 32'hFFFF_FFFF, 1'b1, '{1'b1, 2'd2, EV_LONG}},
		'{MODE_POLL, 3'b100, 32'h0000_0000, 1'b0, NO_MSG},
		'{MODE_POLL, 3'b000, 32'hFFFF_FF00, 1'b0, NO_MSG},
		// hold across the tick wrap
		'{MODE_POLL, 3'b010, 32'h0000_0010, 1'b0, NO_MSG},
		'{MODE_POLL, 3'b010, 32'h0000_02E8, 1'b0, NO_MSG},
		'{MODE_POLL, 3'b010, 32'h0000_02E9, 1'b0, NO_MSG},
		// start tick equal to the current tick: zero elapsed
		'{MODE_POLL, 3'b011, 32'h0000_02E9, 1'b0, NO_MSG},
		'{MODE_READ, 3'b101, 32'h5555_5555, 1'b0, NO_MSG},
		'{MODE_POLL, 3'b000, 32'h0000_02F0, 1'b0, NO_MSG},
		'{MODE_POLL, 3'b000, 32'h0000_0300, 1'b0, NO_MSG},
		'{MODE_READ, 3'b010, 32'hAAAA_AAAA, 1'b0, NO_MSG},
		'{MODE_READ, 3'b000, 32'h0000_0000, 1'b1, NO_MSG}
	};

	button_press_long_press_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Advance the model by one request and return the mailbox it reports.
	function automatic mbox_msg_t predict_mailbox(input logic mode,
			input logic [LEVEL_W-1:0] levels, input logic [TICK_IN_W-1:0] tick);
		mbox_msg_t shown;
		logic [TICK_IN_W-1:0] held;
		if (mode == MODE_READ) begin
			shown = mbox;
			mbox = NO_MSG;
			return shown;
		end
		// Lanes in rising index order, so a later lane overwrites the mailbox.
		for (int b = 0; b < 3; b++) begin
			held = tick - hold_start[b];
			if (!levels[b]) begin
				if (!btn_up[b])
					mbox = '{1'b1, 2'(b), long_hit[b] ? EV_RELEASE_LONG : EV_SHORT};
				btn_up[b] = 1'b1;
				long_hit[b] = 1'b0;
				hold_start[b] = tick;
			end else begin
				if (btn_up[b])
					mbox = '{1'b1, 2'(b), EV_PRESS};
				if (!long_hit[b] && held > long_limit) begin
					long_hit[b] = 1'b1;
					mbox = '{1'b1, 2'(b), EV_LONG};
				end
				btn_up[b] = 1'b0;
			end
		end
		return mbox;
	endfunction

	// Offer one request, hold it until taken, then queue its expected mailbox.
	task automatic send_request(input logic mode, input logic [LEVEL_W-1:0] levels,
			input logic [TICK_IN_W-1:0] tick, input logic has_want, input mbox_msg_t want);
		mbox_msg_t pred;
		// random gaps, except for a burst of back-to-back requests
		while (!(requests_sent >= 500 && requests_sent < 700) && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {5'b0, tick, levels};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = predict_mailbox(mode, levels, tick);
		expected_msgs.push_back(has_want ? want : pred);
		requests_sent++;
	endtask

	// Drop valid and wait until every result is back, plus the output register.
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (expected_msgs.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [THRESH_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		long_limit = value;
	endtask

	task automatic note_mismatch(input string what, input mbox_msg_t want, input mbox_msg_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): expected valid=%0d button=%0d event=%0d, got valid=%0d button=%0d event=%0d",
				what, want.valid, want.button, want.ev, got.valid, got.button, got.ev);
	endtask

	// Check each result against the oldest expectation.
	always @(posedge clk) begin
		mbox_msg_t got;
		mbox_msg_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[0], m_tdata[2:1], m_tdata[4:3]};
			if (expected_msgs.size() == 0) begin
				note_mismatch("unexpected result", NO_MSG, got);
			end else begin
				want = expected_msgs.pop_front();
				if (got.valid !== want.valid || got.button !== want.button || got.ev !== want.ev)
					note_mismatch("mailbox", want, got);
			end
		end
	end

	// Result sink: random stalls, one long hold-off, one stretch always ready.
	initial begin : result_sink
		int taken;
		int hold_left;
		bit hold_done;
		taken = 0;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				taken++;
			if (!hold_done && taken >= 300) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (taken >= 700 && taken < 900) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 24);
			end
		end
	end

	// Watchdog: give up when neither side moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [THRESH_W-1:0]  phase_limit [6];
		logic [TICK_IN_W-1:0] step_cap [6];
		logic [TICK_IN_W-1:0] cursor;
		logic [LEVEL_W-1:0]   held_levels;
		int pick;

		step_cap  = '{32'd4, 32'd20, 32'd800, 32'h7000_0000, 32'h6000_0000, 32'd6};
		s_tvalid  = 1'b0;
		s_tuser   = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].mode, directed_rows[i].levels, directed_rows[i].tick,
				directed_rows[i].has_want, directed_rows[i].want);
		wait_quiet();

		// Thresholds per phase: zero, small, reset value, all ones, random, tiny.
		phase_limit = '{32'd0, 32'd12, 32'd1000, 32'hFFFF_FFFF, $urandom, 32'd3};
		for (int phase = 0; phase < 6; phase++) begin
			set_threshold(phase_limit[phase]);
			cursor = $urandom;
			held_levels = 3'($urandom);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 30) begin
					send_request(MODE_READ, 3'($urandom), $urandom, 1'b0, NO_MSG);
				end else if (pick < 38) begin
					// noise: levels and tick unrelated to the running sequence
					send_request(MODE_POLL, 3'($urandom), $urandom, 1'b0, NO_MSG);
				end else begin
					// advance the tick and flip a few buttons
					cursor += $urandom_range(0, step_cap[phase]);
					for (int b = 0; b < 3; b++)
						if ($urandom_range(99) < 20)
							held_levels[b] = ~held_levels[b];
					send_request(MODE_POLL, held_levels, cursor, 1'b0, NO_MSG);
				end
			end
			wait_quiet();
		end

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
